@@ rtl/core/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  // Kind of root set reported with every result beat
  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_NO_LEAD  = 2'd3
  } root_kind_t;

  // Fixed result field widths
  localparam int REAL_W = 34;
  localparam int IMAG_W = 33;

endpackage

@@ rtl/core/quadratic_root_solver_core.sv @@
// Quadratic root solver: pipelined discriminant, square root and division.
//
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid, in_ready, in_coef_a/b/c            | in
//  out     | out_valid, out_ready, out_root_kind,         | out
//          | out_first_real, out_second_real, out_imag_part|
//
// One beat enters per cycle while the output is not stalled. The pipeline has
// SW = COEF_WIDTH+FRAC_BITS+1 square root stages (one root bit each) and
// QW = COEF_WIDTH+FRAC_BITS+2 divider stages (one quotient bit each).
// Synchronous active-low reset clears every stage valid bit; data needs none.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COEF_WIDTH-1:0]  in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]  in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]  in_coef_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_root_kind,
  output logic [qrs_pkg::REAL_W-1:0]    out_first_real,
  output logic [qrs_pkg::REAL_W-1:0]    out_second_real,
  output logic [qrs_pkg::IMAG_W-1:0]    out_imag_part
);
  import qrs_pkg::*;

  localparam int CW  = COEF_WIDTH;
  localparam int PW  = 2 * CW;              // product width
  localparam int DW  = 2 * CW + 2;          // discriminant width, signed
  localparam int MW  = 2 * CW + 1;          // discriminant magnitude
  localparam int SW  = CW + FRAC_BITS + 1;  // square root width
  localparam int RW  = 2 * SW;              // radicand width
  localparam int NBW = CW + FRAC_BITS + 1;  // -b scaled, signed
  localparam int NW  = CW + FRAC_BITS + 3;  // numerator, signed
  localparam int QW  = NW - 1;              // numerator magnitude / quotient
  localparam int EW1 = (QW + 1 > REAL_W) ? QW + 1 : REAL_W;
  localparam int EW2 = (QW > IMAG_W) ? QW : IMAG_W;

  typedef struct packed {
    root_kind_t              kind;
    logic                    a_neg;
    logic signed [NBW-1:0]   nb;
    logic [CW-1:0]           amag;
  } sq_side_t;

  typedef struct packed {
    root_kind_t kind;
    logic       neg1;
    logic       neg2;
  } dv_side_t;

  logic en;

  // Whole pipeline moves unless the output beat is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: input capture
  logic                  v1_r;
  logic signed [CW-1:0]  a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_coef_a;
      b1_r <= in_coef_b;
      c1_r <= in_coef_c;
    end
  end

  // Stage 2: b*b and a*c
  logic                  v2_r;
  logic signed [CW-1:0]  a2_r, b2_r;
  logic signed [PW-1:0]  bb2_r, ac2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      bb2_r <= b1_r * b1_r;
      ac2_r <= a1_r * c1_r;
    end
  end

  // Stage 3: discriminant
  logic                  v3_r;
  logic signed [CW-1:0]  a3_r, b3_r;
  logic signed [DW-1:0]  d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r <= a2_r;
      b3_r <= b2_r;
      d3_r <= DW'(bb2_r) - (DW'(ac2_r) <<< 2);
    end
  end

  // Stage 4: magnitude, kind and scaled radicand
  logic              sq_v_r    [SW+1];
  logic [RW-1:0]     sq_rem_r  [SW+1];
  logic [SW-1:0]     sq_root_r [SW+1];
  sq_side_t          sq_side_r [SW+1];

  logic signed [DW-1:0] d_abs;
  logic [MW-1:0]        d_mag;
  sq_side_t             side4;

  always_comb begin
    d_abs = d3_r[DW-1] ? -d3_r : d3_r;
    d_mag = d_abs[MW-1:0];
    if (a3_r == '0) begin
      side4.kind = KIND_NO_LEAD;
    end else if (d3_r[DW-1]) begin
      side4.kind = KIND_COMPLEX;
    end else if (d3_r == '0) begin
      side4.kind = KIND_DOUBLE;
    end else begin
      side4.kind = KIND_TWO_REAL;
    end
    side4.a_neg = a3_r[CW-1];
    side4.nb    = -(NBW'(b3_r) <<< FRAC_BITS);
    side4.amag  = a3_r[CW-1] ? CW'(-a3_r) : CW'(a3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= RW'(d_mag) << (2 * FRAC_BITS);
      sq_root_r[0] <= '0;
      sq_side_r[0] <= side4;
    end
  end

  // Square root stages, one root bit per stage, top bit first
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    localparam int K = SW - 1 - i;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = (RW'(sq_root_r[i]) << (K + 1)) | (RW'(1'b1) << (2 * K));
    assign take  = sq_rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[i+1]  <= take ? sq_rem_r[i] - trial : sq_rem_r[i];
        sq_root_r[i+1] <= take ? (sq_root_r[i] | (SW'(1'b1) << K)) : sq_root_r[i];
        sq_side_r[i+1] <= sq_side_r[i];
      end
    end
  end

  // Numerator stage: three lanes share divisor 2|a|
  logic              dv_v_r    [QW+1];
  logic [CW:0]       dv_den_r  [QW+1];
  dv_side_t          dv_side_r [QW+1];
  logic [CW:0]       dv_rem_r  [3][QW+1];
  logic [QW-1:0]     dv_nq_r   [3][QW+1];

  sq_side_t          sn;
  logic signed [NW-1:0] s_ext, add_s, n1, n2, ni;
  logic [QW-1:0]     m1, m2, mi;

  always_comb begin
    sn    = sq_side_r[SW];
    s_ext = NW'(signed'({1'b0, sq_root_r[SW]}));
    add_s = (sn.kind == KIND_TWO_REAL) ? s_ext : '0;
    n1    = NW'(sn.nb) + add_s;
    n2    = NW'(sn.nb) - add_s;
    ni    = (sn.kind == KIND_COMPLEX) ? s_ext : '0;
    m1    = n1[NW-1] ? QW'(-n1) : QW'(n1);
    m2    = n2[NW-1] ? QW'(-n2) : QW'(n2);
    mi    = QW'(ni);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den_r[0]       <= {sn.amag, 1'b0};
      dv_side_r[0].kind <= sn.kind;
      dv_side_r[0].neg1 <= n1[NW-1] ^ sn.a_neg;
      dv_side_r[0].neg2 <= n2[NW-1] ^ sn.a_neg;
      dv_rem_r[0][0]    <= '0;
      dv_rem_r[1][0]    <= '0;
      dv_rem_r[2][0]    <= '0;
      dv_nq_r[0][0]     <= m1;
      dv_nq_r[1][0]     <= m2;
      dv_nq_r[2][0]     <= mi;
    end
  end

  // Restoring divider stages, one quotient bit per stage per lane
  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den_r[j+1]  <= dv_den_r[j];
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW+1:0] tmp;
      logic          ge;

      assign tmp = {dv_rem_r[l][j], dv_nq_r[l][j][QW-1]};
      assign ge  = tmp >= {1'b0, dv_den_r[j]};

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[l][j+1] <= ge ? (CW+1)'(tmp - {1'b0, dv_den_r[j]}) : tmp[CW:0];
          dv_nq_r[l][j+1]  <= {dv_nq_r[l][j][QW-2:0], ge};
        end
      end
    end
  end

  // Output stage: apply signs, fit to field widths, zero the roots when a is zero
  dv_side_t              so;
  logic signed [QW:0]    sv1, sv2;
  logic signed [EW1-1:0] ex1, ex2;
  logic [EW2-1:0]        exi;
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [REAL_W-1:0]     out_first_r, out_second_r;
  logic [IMAG_W-1:0]     out_imag_r;

  always_comb begin
    so  = dv_side_r[QW];
    sv1 = signed'({1'b0, dv_nq_r[0][QW]});
    sv2 = signed'({1'b0, dv_nq_r[1][QW]});
    if (so.neg1) begin
      sv1 = -sv1;
    end
    if (so.neg2) begin
      sv2 = -sv2;
    end
    ex1 = EW1'(sv1);
    ex2 = EW1'(sv2);
    exi = EW2'(dv_nq_r[2][QW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= so.kind;
      if (so.kind == KIND_NO_LEAD) begin
        out_first_r  <= '0;
        out_second_r <= '0;
        out_imag_r   <= '0;
      end else begin
        out_first_r  <= ex1[REAL_W-1:0];
        out_second_r <= ex2[REAL_W-1:0];
        out_imag_r   <= exi[IMAG_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_kind   = out_kind_r;
  assign out_first_real  = out_first_r;
  assign out_second_real = out_second_r;
  assign out_imag_part   = out_imag_r;

endmodule

@@ rtl/core/qrs_checker.sv @@
// Port-level checks for the quadratic root solver, bound to the top level.
module qrs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_root_kind,
  input logic [qrs_pkg::REAL_W-1:0] out_first_real,
  input logic [qrs_pkg::REAL_W-1:0] out_second_real,
  input logic [qrs_pkg::IMAG_W-1:0] out_imag_part
);
  import qrs_pkg::*;

  // Zero leading coefficient gives all-zero roots
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_NO_LEAD |->
      out_first_real == '0 && out_second_real == '0 && out_imag_part == '0)
    else $error("no-lead beat with nonzero roots");

  // Real root sets carry no imaginary part
  a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_kind == KIND_TWO_REAL || out_root_kind == KIND_DOUBLE) |->
      out_imag_part == '0)
    else $error("real roots with imaginary part");

  // Double root and complex pair share one real part
  a_shared_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_kind == KIND_DOUBLE || out_root_kind == KIND_COMPLEX) |->
      out_first_real == out_second_real)
    else $error("shared real part differs");

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_root_kind) && $stable(out_first_real) &&
      $stable(out_second_real) && $stable(out_imag_part))
    else $error("result beat changed while stalled");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_root_kind   (out_root_kind),
  .out_first_real  (out_first_real),
  .out_second_real (out_second_real),
  .out_imag_part   (out_imag_part)
);

@@ tb/tb_quadratic_root_solver_core.sv @@
// Testbench for the quadratic root solver core: directed and random coefficient beats.
module tb_quadratic_root_solver_core;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LATENCY = 6 + (CW + FB + 1) + (CW + FB + 2);
  localparam int N_RANDOM = 1500;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    root_kind_t       kind;
    logic [REAL_W-1:0] first_real;
    logic [REAL_W-1:0] second_real;
    logic [IMAG_W-1:0] imag_part;
  } roots_t;

  // Floored integer square root of a wide unsigned value
  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (64'd1 << k);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  // Expected roots for one coefficient set
  function automatic roots_t solve_roots(logic signed [CW-1:0] a_in,
                                         logic signed [CW-1:0] b_in,
                                         logic signed [CW-1:0] c_in);
    roots_t r;
    longint a, b, c, nb, den, s, r1, r2, im;
    logic signed [127:0] disc;
    logic [127:0] mag;
    a = a_in; b = b_in; c = c_in;
    r = '0;
    if (a == 0) begin
      r.kind = KIND_NO_LEAD;
      return r;
    end
    disc = 128'(b * b) - 4 * 128'(a * c);
    mag = disc < 0 ? -disc : disc;
    s = longint'(isqrt128(mag << (2 * FB)));
    nb = -b * (64'sd1 <<< FB);
    den = 2 * a;
    im = 0;
    if (disc > 0) begin
      r.kind = KIND_TWO_REAL;
      r1 = (nb + s) / den;
      r2 = (nb - s) / den;
    end else begin
      r.kind = disc == 0 ? KIND_DOUBLE : KIND_COMPLEX;
      r1 = nb / den;
      r2 = r1;
      if (disc < 0) im = s / (den < 0 ? -den : den);
    end
    r.first_real  = r1[REAL_W-1:0];
    r.second_real = r2[REAL_W-1:0];
    r.imag_part   = im[IMAG_W-1:0];
    return r;
  endfunction

  // Holds expected roots in order and checks result beats against them
  class roots_scoreboard;
    roots_t pending[$];
    int mismatches;

    function void note_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                             logic signed [CW-1:0] c);
      pending.push_back(solve_roots(a, b, c));
    endfunction

    function void check_roots(roots_t got);
      roots_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: kind %0d/%0d first %h/%h second %h/%h imag %h/%h",
                   want.kind, got.kind, want.first_real, got.first_real,
                   want.second_real, got.second_real, want.imag_part, got.imag_part);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_root_kind;
  logic [REAL_W-1:0] out_first_real, out_second_real;
  logic [IMAG_W-1:0] out_imag_part;

  roots_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  always #5 clk = ~clk;

  quadratic_root_solver_core #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_root_kind(out_root_kind), .out_first_real(out_first_real),
    .out_second_real(out_second_real), .out_imag_part(out_imag_part)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quadratic_root_solver_core failed");
      $finish;
    end
  end

  // Note accepted input beats and check accepted result beats
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_coefs(in_coef_a, in_coef_b, in_coef_c);
    if (rst_n && out_valid && out_ready)
      sb.check_roots({root_kind_t'(out_root_kind), out_first_real, out_second_real,
                      out_imag_part});
  end

  // Offer one coefficient beat and wait for acceptance; random gap first
  task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    int gap;
    if (!quiet_phase && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random coefficient with a bias towards small values and extremes
  function automatic logic [CW-1:0] pick_coef();
    case ($urandom_range(5))
      0: return CW'($urandom_range(0, 6)) - CW'(3);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      2: return CW'($urandom_range(0, 64)) - CW'(32);
      default: return CW'($urandom());
    endcase
  endfunction

  // Result side: random stall bursts, one long hold-off
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet_phase && $urandom_range(3) == 0) begin
        stall = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    logic [CW-1:0] a, b, c;
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero lead, two real, double, complex, extremes
    send_coefs(16'd0, 16'd5, 16'd3);
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd1, -16'sd3, 16'd2);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(-16'sd1, 16'd0, 16'd1);
    send_coefs(16'd2, 16'd4, 16'd2);
    send_coefs(16'd3, 16'd1, 16'd7);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'd0, 16'h7fff);
    send_coefs(16'h7fff, 16'd0, 16'h8000);
    send_coefs(16'h8000, 16'h8000, 16'd0);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'd1, 16'd0, 16'd0);
    send_coefs(-16'sd5, 16'd3, 16'd0);
    send_coefs(16'd1, 16'd1, 16'h8000);

    // Long receiver hold-off while beats keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_coefs(pick_coef(), pick_coef(), pick_coef());

    // Random beats; double roots forced now and then
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) quiet_phase = 1'b1;
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      if ($urandom_range(9) == 0) begin
        // b = 2k, a = 1, c = k*k gives a zero discriminant
        a = 16'd1;
        b = CW'($urandom_range(0, 300)) - CW'(150);
        c = CW'(($signed(b) / 2) * ($signed(b) / 2));
        b = CW'(($signed(b) / 2) * 2);
      end
      send_coefs(a, b, c);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_quadratic_root_solver_core passed");
    else
      $display("tb_quadratic_root_solver_core failed");
    $finish;
  end
endmodule
